// ===== hw/rtl/spm_pkg.sv =====
package spm_pkg;

  // Default sizes for the top-level parameters
  localparam int MAX_PATTERN_DEF  = 16;
  localparam int OFFSET_WIDTH_DEF = 40;

  // Fixed field and register widths
  localparam int LEN_W          = 5;
  localparam int COUNT_W        = 16;
  localparam int OFFSET_FIELD_W = 40;
  localparam int PDATA_W        = 64;
  localparam int PADDR_W        = 5;
  localparam int PAT_BYTES      = 16;

  // Result queue depth, a power of two of at least two
  localparam int FIFO_DEPTH = 4;

  localparam logic [COUNT_W-1:0] MATCH_LIMIT_RST = 16'd100;

  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    STATUS_FOUND     = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_INVALID   = 2'd2,
    STATUS_TRUNCATED = 2'd3
  } spm_status_t;

  typedef enum logic [1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2,
    REG_MATCH_LIMIT    = 2'd3
  } spm_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } spm_in_t;

  typedef struct packed {
    logic                      result_kind;
    logic [OFFSET_FIELD_W-1:0] match_offset;
    logic [COUNT_W-1:0]        total_found;
    logic [1:0]                search_status;
    logic                      last_result;
  } spm_out_t;

endpackage

// ===== hw/rtl/spm_cell.sv =====
module spm_cell
  import spm_pkg::*;
(
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] d_in,
  input  logic [7:0] expected,
  output logic [7:0] q,
  output logic       eq
);

  logic [7:0] byte_r;

  // Take the neighbor's byte on every accepted request
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= d_in;
    end
  end

  // Compare the byte this cell holds after the shift
  assign eq = (d_in == expected);
  assign q  = byte_r;

endmodule

// ===== hw/rtl/spm_result_fifo.sv =====
module spm_result_fifo
  import spm_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push0,
  input  logic     push1,
  input  spm_out_t din0,
  input  spm_out_t din1,
  input  logic     pop,
  output spm_out_t dout,
  output logic     not_empty,
  output logic     room2
);

  localparam int PW = $clog2(DEPTH);

  spm_out_t         mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      count_r, count_nxt;
  logic [PW-1:0]    wr_ptr_p1;

  assign wr_ptr_p1 = PW'(wr_ptr_r + PW'(1));

  // Store up to two results per cycle, second one behind the first
  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_ptr_r] <= din0;
    end
    if (push1) begin
      mem[wr_ptr_p1] <= din1;
    end
  end

  always_comb begin
    wr_ptr_nxt = PW'(wr_ptr_r + PW'(push0) + PW'(push1));
    rd_ptr_nxt = PW'(rd_ptr_r + PW'(pop));
    count_nxt  = (PW+1)'(count_r + (PW+1)'(push0) + (PW+1)'(push1) - (PW+1)'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign dout      = mem[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign room2     = (count_r <= (PW+1)'(DEPTH - 2));

endmodule

// ===== hw/rtl/streaming_pattern_search_unit.sv =====
// A result is written into the result queue when its byte is accepted; a summary
// that follows a match report on the same byte is queued right behind it.
// Throughput: one byte per cycle, set by the shift of the cell chain; the
// result queue holds four results and takes a byte while room for two remains.
// Reset (rst_n low, synchronous) clears the counters, the queue and the
// registers to their defaults; the byte window keeps whatever it holds.
module streaming_pattern_search_unit
  import spm_pkg::*;
#(
  parameter int MAX_PATTERN  = MAX_PATTERN_DEF,
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spm_in_t            in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output spm_out_t           out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // Configuration registers
  logic [PDATA_W-1:0] pattern_low_r;
  logic [PDATA_W-1:0] pattern_high_r;
  logic [LEN_W-1:0]   pattern_length_r;
  logic [COUNT_W-1:0] match_limit_r;

  // Stream state
  logic [OFFSET_WIDTH-1:0] bytes_seen_r;
  logic [COUNT_W-1:0]      match_count_r;
  logic                    limit_reached_r;

  spm_reg_t               reg_sel;
  logic                   cfg_wr;
  logic [2*PDATA_W-1:0]   pat_all;
  logic                   accept;
  logic                   eos;
  logic [7:0]             win   [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq_v;
  logic [MAX_PATTERN-1:0] use_v;
  logic                   all_eq;
  logic                   len_valid;
  logic                   pos_sat;
  logic [OFFSET_WIDTH-1:0] seen_inc;
  logic [OFFSET_WIDTH-1:0] len_ext;
  logic                   covered;
  logic                   hit;
  logic [OFFSET_WIDTH-1:0] offset;
  logic [63:0]            offset_wide;
  logic [COUNT_W-1:0]     count_inc;
  logic [COUNT_W-1:0]     count_after;
  logic [COUNT_W-1:0]     limit_eff;
  logic                   limit_after;
  spm_out_t               match_rec;
  spm_out_t               sum_rec;
  spm_out_t               res0;
  logic                   push0;
  logic                   push1;
  logic                   fifo_room2;
  logic                   fifo_not_empty;

  // Register access
  assign reg_sel = spm_reg_t'(paddr[PADDR_W-1:PADDR_W-2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
      pattern_length_r <= '0;
      match_limit_r    <= MATCH_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_PATTERN_LOW:    pattern_low_r    <= pwdata;
        REG_PATTERN_HIGH:   pattern_high_r   <= pwdata;
        REG_PATTERN_LENGTH: pattern_length_r <= pwdata[LEN_W-1:0];
        REG_MATCH_LIMIT:    match_limit_r    <= pwdata[COUNT_W-1:0];
        default:            pattern_low_r    <= pattern_low_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PATTERN_LOW:    prdata = pattern_low_r;
      REG_PATTERN_HIGH:   prdata = pattern_high_r;
      REG_PATTERN_LENGTH: prdata = PDATA_W'(pattern_length_r);
      REG_MATCH_LIMIT:    prdata = PDATA_W'(match_limit_r);
      default:            prdata = '0;
    endcase
  end

  assign pat_all = {pattern_high_r, pattern_low_r};
  assign accept  = in_valid && in_ready;
  assign eos     = in_data.end_of_stream;

  // Cell chain: cell k holds window entry k and checks pattern byte len-1-k
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [7:0]       d_in;
    logic [LEN_W-1:0] exp_idx;
    logic [7:0]       expected;

    if (k == 0) begin : g_head
      assign d_in = in_data.data_byte;
    end else begin : g_link
      assign d_in = win[k-1];
    end

    assign exp_idx  = LEN_W'(pattern_length_r - LEN_W'(k) - LEN_W'(1));
    assign expected = pat_all[exp_idx[3:0]*8 +: 8];
    assign use_v[k] = (LEN_W'(k) < pattern_length_r);

    spm_cell u_cell (
      .clk      (clk),
      .shift_en (accept),
      .d_in     (d_in),
      .expected (expected),
      .q        (win[k]),
      .eq       (eq_v[k])
    );
  end

  assign all_eq = &(eq_v | ~use_v);

  // Match decision on the window as it stands after this byte
  assign len_valid = (pattern_length_r != '0) &&
                     (pattern_length_r <= LEN_W'(MAX_PATTERN));
  assign pos_sat   = &bytes_seen_r;
  assign seen_inc  = pos_sat ? bytes_seen_r : OFFSET_WIDTH'(bytes_seen_r + 1'b1);
  assign len_ext   = OFFSET_WIDTH'(pattern_length_r);
  assign covered   = (seen_inc >= len_ext);
  assign hit       = len_valid && !limit_reached_r && covered && all_eq;

  assign offset      = pos_sat ? '1 :
                       OFFSET_WIDTH'(bytes_seen_r - (len_ext - OFFSET_WIDTH'(1)));
  assign offset_wide = 64'(offset);

  // Count with saturation, and check the limit (zero acts as one)
  assign count_inc   = (match_count_r != '1) ? COUNT_W'(match_count_r + 1'b1)
                                             : match_count_r;
  assign count_after = hit ? count_inc : match_count_r;
  assign limit_eff   = (match_limit_r == '0) ? COUNT_W'(1) : match_limit_r;
  assign limit_after = limit_reached_r || (hit && (count_inc >= limit_eff));

  // Build the match report and the summary
  always_comb begin
    match_rec.result_kind   = KIND_MATCH;
    match_rec.match_offset  = offset_wide[OFFSET_FIELD_W-1:0];
    match_rec.total_found   = count_inc;
    match_rec.search_status = STATUS_FOUND;
    match_rec.last_result   = !eos;

    sum_rec.result_kind  = KIND_SUMMARY;
    sum_rec.match_offset = '0;
    sum_rec.total_found  = count_after;
    sum_rec.last_result  = 1'b1;
    priority if (!len_valid || !covered) begin
      sum_rec.search_status = STATUS_INVALID;
      sum_rec.total_found   = '0;
    end else if (limit_after) begin
      sum_rec.search_status = STATUS_TRUNCATED;
    end else if (count_after == '0) begin
      sum_rec.search_status = STATUS_NOT_FOUND;
    end else begin
      sum_rec.search_status = STATUS_FOUND;
    end
  end

  // Advance the stream state; drop it back to zero after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r    <= '0;
      match_count_r   <= '0;
      limit_reached_r <= 1'b0;
    end else if (accept) begin
      if (eos) begin
        bytes_seen_r    <= '0;
        match_count_r   <= '0;
        limit_reached_r <= 1'b0;
      end else begin
        bytes_seen_r    <= seen_inc;
        match_count_r   <= count_after;
        limit_reached_r <= limit_after;
      end
    end
  end

  // Queue the results in order: match report first, then summary
  assign res0  = hit ? match_rec : sum_rec;
  assign push0 = accept && (hit || eos);
  assign push1 = accept && hit && eos;

  spm_result_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (push0),
    .push1     (push1),
    .din0      (res0),
    .din1      (sum_rec),
    .pop       (out_valid && out_ready),
    .dout      (out_data),
    .not_empty (fifo_not_empty),
    .room2     (fifo_room2)
  );

  assign out_valid = fifo_not_empty;
  assign in_ready  = fifo_room2;

endmodule

// ===== tb/tb_streaming_pattern_search_unit.sv =====
`timescale 1ns / 1ps

module tb_streaming_pattern_search_unit;
  import spm_pkg::*;

  localparam logic [39:0] OFFSET_TOP = '1;
  localparam int LONG_HOLD = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  spm_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  spm_out_t out_data;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // Requests waiting for the driver, and search results still owed by the block
  spm_in_t bytes_pending[$];
  spm_out_t results_due[$];

  // Shadow copy of the registers
  logic [63:0] sh_pat_lo;
  logic [63:0] sh_pat_hi;
  logic [4:0] sh_pat_len;
  logic [15:0] sh_limit;

  // Shadow copy of the search state
  logic [7:0] sh_window[PAT_BYTES];
  logic [39:0] sh_seen;
  logic [15:0] sh_count;
  logic sh_limit_hit;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int n_mismatch = 0;

  streaming_pattern_search_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pattern byte j of the shadow registers
  function automatic logic [7:0] pattern_at(int j);
    if (j < 8) return sh_pat_lo[8*j +: 8];
    return sh_pat_hi[8*(j-8) +: 8];
  endfunction

  // Shift one byte into the shadow window and queue the results it causes
  task automatic search_step(spm_in_t req);
    logic [39:0] pos;
    logic [15:0] lim;
    bit sat;
    bit hit;
    bit len_ok;
    int len;
    spm_out_t r;
    pos = sh_seen;
    sat = (sh_seen == OFFSET_TOP);
    len = int'(sh_pat_len);
    len_ok = (sh_pat_len != 0) && (sh_pat_len <= PAT_BYTES);
    for (int i = PAT_BYTES - 1; i > 0; i--) sh_window[i] = sh_window[i-1];
    sh_window[0] = req.data_byte;
    if (!sat) sh_seen = sh_seen + 40'd1;

    if (len_ok && !sh_limit_hit && sh_seen >= 40'(sh_pat_len)) begin
      hit = 1'b1;
      for (int j = 0; j < len; j++) begin
        if (sh_window[len-1-j] != pattern_at(j)) hit = 1'b0;
      end
      if (hit) begin
        lim = (sh_limit == 16'd0) ? 16'd1 : sh_limit;
        if (sh_count != 16'hFFFF) sh_count = sh_count + 16'd1;
        if (sh_count >= lim) sh_limit_hit = 1'b1;
        r.result_kind = KIND_MATCH;
        r.match_offset = sat ? OFFSET_TOP : pos - 40'(len - 1);
        r.total_found = sh_count;
        r.search_status = STATUS_FOUND;
        r.last_result = !req.end_of_stream;
        results_due.push_back(r);
      end
    end

    if (req.end_of_stream) begin
      r.result_kind = KIND_SUMMARY;
      r.match_offset = '0;
      r.total_found = sh_count;
      r.last_result = 1'b1;
      if (!len_ok || sh_seen < 40'(sh_pat_len)) begin
        r.search_status = STATUS_INVALID;
        r.total_found = '0;
      end else if (sh_limit_hit) begin
        r.search_status = STATUS_TRUNCATED;
      end else if (sh_count == 16'd0) begin
        r.search_status = STATUS_NOT_FOUND;
      end else begin
        r.search_status = STATUS_FOUND;
      end
      results_due.push_back(r);
      sh_seen = '0;
      sh_count = '0;
      sh_limit_hit = 1'b0;
    end
  endtask

  task automatic report_bad(string what, spm_out_t want, spm_out_t got);
    n_mismatch++;
    if (n_mismatch <= 10) begin
      $display("%s: want kind %0d off %0h total %0d status %0d last %0d",
               what, want.result_kind, want.match_offset, want.total_found,
               want.search_status, want.last_result);
      $display("%s: got kind %0d off %0h total %0d status %0d last %0d",
               what, got.result_kind, got.match_offset, got.total_found,
               got.search_status, got.last_result);
    end
  endtask

  // Drive the input channel from the pending requests
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (bytes_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= bytes_pending.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Drive out_ready: random stalls, or a long hold when requested
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each result against the oldest owed one, then predict from accepted bytes
  always @(posedge clk) begin
    spm_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        report_bad("unexpected result", '0, out_data);
      end else begin
        want = results_due.pop_front();
        if (out_data.result_kind !== want.result_kind ||
            out_data.match_offset !== want.match_offset ||
            out_data.total_found !== want.total_found ||
            out_data.search_status !== want.search_status ||
            out_data.last_result !== want.last_result)
          report_bad("mismatch", want, out_data);
      end
    end
    if (rst_n && in_valid && in_ready) search_step(in_data);
  end

  task automatic push_byte(logic [7:0] b, bit eos);
    spm_in_t req;
    req.data_byte = b;
    req.end_of_stream = eos;
    bytes_pending.push_back(req);
  endtask

  // Hold until every request is taken and every result is back, then let the block settle
  task automatic wait_idle();
    do @(negedge clk); while (bytes_pending.size() != 0 || in_valid || results_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // Register write with a setup and an access phase; the shadow follows once the access cycle is done
  task automatic reg_write(spm_reg_t r, logic [63:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 3'b000};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    case (r)
      REG_PATTERN_LOW: sh_pat_lo = v;
      REG_PATTERN_HIGH: sh_pat_hi = v;
      REG_PATTERN_LENGTH: sh_pat_len = v[4:0];
      REG_MATCH_LIMIT: sh_limit = v[15:0];
      default: ;
    endcase
  endtask

  initial begin
    logic [7:0] pat[PAT_BYTES];
    logic [7:0] alpha0;
    logic [7:0] alpha1;
    logic [7:0] sbuf[$];
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0] len;
    logic [15:0] lim;
    int plen;
    int slen;
    int fed;
    bit noise;
    bit leave_open;

    sh_pat_lo = '0;
    sh_pat_hi = '0;
    sh_pat_len = '0;
    sh_limit = MATCH_LIMIT_RST;
    for (int i = 0; i < PAT_BYTES; i++) sh_window[i] = '0;
    sh_seen = '0;
    sh_count = '0;
    sh_limit_hit = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset length of zero: invalid pattern
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    wait_idle();

    // Two-byte pattern: overlapping hits, a hit on the final byte,
    // a stream shorter than the pattern, and a stream with no hit
    reg_write(REG_PATTERN_LOW, 64'h0000_0000_0000_AAAA);
    reg_write(REG_PATTERN_HIGH, 64'h0);
    reg_write(REG_PATTERN_LENGTH, 64'd2);
    push_byte(8'hAA, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'hAA, 1'b1);
    push_byte(8'hAA, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b1);
    wait_idle();

    // Zero limit acts like one: truncated after the first hit
    reg_write(REG_MATCH_LIMIT, 64'd0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'hAA, 1'b1);
    wait_idle();

    // Random phases; each one changes the configuration and the idling mix
    for (int p = 0; p < 12; p++) begin
      if (p == 0) begin
        alpha0 = 8'hFF;
        alpha1 = 8'h00;
        len = 5'd16;
        lim = 16'hFFFF;
      end else begin
        alpha0 = 8'($urandom);
        alpha1 = 8'($urandom);
        case ($urandom_range(9))
          0: len = 5'd1;
          1: len = 5'd16;
          2: len = 5'd0;
          3: len = 5'($urandom_range(17, 31));
          default: len = 5'($urandom_range(2, 15));
        endcase
        case ($urandom_range(7))
          0: lim = 16'd0;
          1: lim = 16'd1;
          2: lim = 16'hFFFF;
          3: lim = MATCH_LIMIT_RST;
          default: lim = 16'($urandom_range(2, 6));
        endcase
      end
      for (int i = 0; i < PAT_BYTES; i++) begin
        if ($urandom_range(4) == 0) pat[i] = 8'($urandom);
        else pat[i] = $urandom_range(1) ? alpha0 : alpha1;
      end
      for (int i = 0; i < 8; i++) begin
        lo[8*i +: 8] = pat[i];
        hi[8*i +: 8] = pat[i+8];
      end
      reg_write(REG_PATTERN_LOW, lo);
      reg_write(REG_PATTERN_HIGH, hi);
      reg_write(REG_PATTERN_LENGTH, {59'd0, len});
      reg_write(REG_MATCH_LIMIT, {48'd0, lim});

      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 61; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 61; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      plen = (len >= 1 && len <= PAT_BYTES) ? int'(len) : PAT_BYTES;
      leave_open = (p != 11) && ($urandom_range(4) == 0);

      // Build streams: mostly pattern copies in a two-letter background
      fed = 0;
      while (fed < 100) begin
        slen = ($urandom_range(9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 24);
        noise = ($urandom_range(9) == 0);
        sbuf.delete();
        while (sbuf.size() < slen) begin
          if (!noise && $urandom_range(2) == 0) begin
            for (int j = 0; j < plen; j++) sbuf.push_back(pat[j]);
            // break a copy now and then
            if ($urandom_range(4) == 0)
              sbuf[sbuf.size() - 1 - $urandom_range(plen - 1)] = 8'($urandom);
          end else if (!noise && $urandom_range(9) < 7) begin
            sbuf.push_back($urandom_range(1) ? alpha0 : alpha1);
          end else begin
            sbuf.push_back(8'($urandom));
          end
        end
        fed += sbuf.size();
        for (int k = 0; k < sbuf.size(); k++)
          push_byte(sbuf[k], (k == sbuf.size() - 1) && !(leave_open && fed >= 100));
      end

      // Stall the receiver long enough to fill the block while requests keep coming
      if (p == 0) hold_req = hold_req + 1;
      wait_idle();
    end

    repeat (20) @(negedge clk);
    if (n_mismatch == 0 && results_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
